// ----- hdl/rcb_pkg.sv -----
// ----------------------------------------------------------------------------
// rcb_pkg
// shared constants, register map and color helpers for the rgb565 pixel
// write stage
// ----------------------------------------------------------------------------
package rcb_pkg;

	// screen geometry
	localparam int SCREEN_WIDTH  = 160;
	localparam int SCREEN_HEIGHT = 128;

	localparam int ADDR_W  = 15;
	localparam int PADDR_W = 5;
	localparam int PDATA_W = 32;

	// register map, index is paddr[4:2]
	typedef enum logic [2:0] {
		REG_DRAW_COLOR   = 3'd0,
		REG_DRAW_ALPHA   = 3'd1,
		REG_BLEND_ENABLE = 3'd2,
		REG_CLIP_ENABLE  = 3'd3,
		REG_CLIP_ORIGIN  = 3'd4,
		REG_CLIP_SIZE    = 3'd5,
		REG_TEX_MODULATE = 3'd6,
		REG_COLOR_KEY    = 3'd7
	} reg_idx_t;

	typedef enum logic {
		OP_FILL = 1'b0,
		OP_COPY = 1'b1
	} op_t;

	localparam logic [23:0] DRAW_COLOR_RST = 24'hFF_FFFF;
	localparam logic [7:0]  DRAW_ALPHA_RST = 8'hFF;
	localparam logic [21:0] CLIP_SIZE_RST  =
		{11'(SCREEN_HEIGHT), 11'(SCREEN_WIDTH)};
	localparam logic [23:0] TEX_MOD_RST    = 24'hFF_FFFF;

	// channel widening tables, c*255/31 and c*255/63 with truncation
	typedef logic [7:0] exp5_t [32];
	typedef logic [7:0] exp6_t [64];

	function automatic exp5_t build_exp5();
		exp5_t r;
		for (int i = 0; i < 32; i++) begin
			r[i] = 8'((i * 255) / 31);
		end
		return r;
	endfunction

	function automatic exp6_t build_exp6();
		exp6_t r;
		for (int i = 0; i < 64; i++) begin
			r[i] = 8'((i * 255) / 63);
		end
		return r;
	endfunction

	localparam exp5_t EXP5 = build_exp5();
	localparam exp6_t EXP6 = build_exp6();

	// floor(x/255), exact for x below 65280
	function automatic logic [7:0] div255(logic [15:0] x);
		logic [16:0] t;
		t = {1'b0, x} + 17'(x[15:8]) + 17'd1;
		return t[15:8];
	endfunction

	function automatic logic [15:0] pack565(logic [7:0] r, logic [7:0] g, logic [7:0] b);
		return {r[7:3], g[7:2], b[7:3]};
	endfunction

	// (s*a + d*(255-a))/255
	function automatic logic [7:0] mix(logic [7:0] s, logic [7:0] d, logic [7:0] a);
		logic [15:0] ps;
		logic [15:0] pd;
		ps = s * a;
		pd = d * (8'hFF - a);
		return div255(16'(ps + pd));
	endfunction

endpackage

// ----- hdl/rgb565_clip_blend_pixel.sv -----
// ----------------------------------------------------------------------------
// rgb565_clip_blend_pixel
// pixel write stage of a 2d renderer on an rgb565 framebuffer: screen and
// clip test, fill with optional alpha blend, texel copy with color key and
// per-channel modulation
// ----------------------------------------------------------------------------
//
// channel   handshake                    payload
// -------   ---------------------------  -----------------------------------
// input     start, busy (always low)     operation, pos_x, pos_y, texel,
//                                        dest_pixel
// result    done, one-cycle strobe       write_enable, pixel_address,
//                                        pixel_color
// config    psel/penable/pwrite, pready  paddr, pwdata, prdata
//
// one transfer is taken every cycle; its result passes the input register,
// then the color/address logic into the result register
// busy never rises, so items can follow back to back without gaps
// the receiver cannot stall: each result is on the ports for one cycle only
// arst_n clears the pipeline valid bits and loads the register reset values
// ----------------------------------------------------------------------------
module rgb565_clip_blend_pixel (
	input  logic                         clk,
	input  logic                         arst_n,
	// item transfer
	input  logic                         start,
	output logic                         busy,
	input  logic                         operation,
	input  logic signed [10:0]           pos_x,
	input  logic signed [10:0]           pos_y,
	input  logic [15:0]                  texel,
	input  logic [15:0]                  dest_pixel,
	// result transfer
	output logic                         done,
	output logic                         write_enable,
	output logic [rcb_pkg::ADDR_W-1:0]   pixel_address,
	output logic [15:0]                  pixel_color,
	// register port
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [rcb_pkg::PADDR_W-1:0]  paddr,
	input  logic [rcb_pkg::PDATA_W-1:0]  pwdata,
	output logic [rcb_pkg::PDATA_W-1:0]  prdata,
	output logic                         pready
);
	import rcb_pkg::*;

	// ------------------------------------------------------------------
	// configuration registers
	// ------------------------------------------------------------------
	logic [23:0] draw_color_q;
	logic [7:0]  draw_alpha_q;
	logic        blend_enable_q;
	logic        clip_enable_q;
	logic [21:0] clip_origin_q;
	logic [21:0] clip_size_q;
	logic [23:0] tex_modulate_q;
	logic [16:0] color_key_q;

	reg_idx_t reg_idx;
	logic     reg_write;

	assign pready    = 1'b1;
	assign reg_idx   = reg_idx_t'(paddr[4:2]);
	assign reg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			draw_color_q   <= DRAW_COLOR_RST;
			draw_alpha_q   <= DRAW_ALPHA_RST;
			blend_enable_q <= 1'b0;
			clip_enable_q  <= 1'b0;
			clip_origin_q  <= '0;
			clip_size_q    <= CLIP_SIZE_RST;
			tex_modulate_q <= TEX_MOD_RST;
			color_key_q    <= '0;
		end else if (reg_write) begin
			unique case (reg_idx)
				REG_DRAW_COLOR:   draw_color_q   <= pwdata[23:0];
				REG_DRAW_ALPHA:   draw_alpha_q   <= pwdata[7:0];
				REG_BLEND_ENABLE: blend_enable_q <= pwdata[0];
				REG_CLIP_ENABLE:  clip_enable_q  <= pwdata[0];
				REG_CLIP_ORIGIN:  clip_origin_q  <= pwdata[21:0];
				REG_CLIP_SIZE:    clip_size_q    <= pwdata[21:0];
				REG_TEX_MODULATE: tex_modulate_q <= pwdata[23:0];
				REG_COLOR_KEY:    color_key_q    <= pwdata[16:0];
				default:          ;
			endcase
		end
	end

	// read back, zero-extended to the data width
	always_comb begin
		unique case (reg_idx)
			REG_DRAW_COLOR:   prdata = 32'(draw_color_q);
			REG_DRAW_ALPHA:   prdata = 32'(draw_alpha_q);
			REG_BLEND_ENABLE: prdata = 32'(blend_enable_q);
			REG_CLIP_ENABLE:  prdata = 32'(clip_enable_q);
			REG_CLIP_ORIGIN:  prdata = 32'(clip_origin_q);
			REG_CLIP_SIZE:    prdata = 32'(clip_size_q);
			REG_TEX_MODULATE: prdata = 32'(tex_modulate_q);
			REG_COLOR_KEY:    prdata = 32'(color_key_q);
			default:          prdata = '0;
		endcase
	end

	// ------------------------------------------------------------------
	// stage 1: input register
	// ------------------------------------------------------------------
	logic               valid_s1;
	logic               operation_s1;
	logic signed [10:0] pos_x_s1;
	logic signed [10:0] pos_y_s1;
	logic [15:0]        texel_s1;
	logic [15:0]        dest_pixel_s1;

	// every cycle is open for a new transfer
	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			operation_s1  <= operation;
			pos_x_s1      <= pos_x;
			pos_y_s1      <= pos_y;
			texel_s1      <= texel;
			dest_pixel_s1 <= dest_pixel;
		end
	end

	// ------------------------------------------------------------------
	// position test: screen, then optional clip rectangle
	// ------------------------------------------------------------------
	logic signed [12:0] px, py;
	logic signed [12:0] clip_x, clip_y;
	logic signed [12:0] clip_x_end, clip_y_end;
	logic               on_screen, in_clip, pos_ok;

	assign px         = 13'(pos_x_s1);
	assign py         = 13'(pos_y_s1);
	assign clip_x     = 13'($signed(clip_origin_q[10:0]));
	assign clip_y     = 13'($signed(clip_origin_q[21:11]));
	assign clip_x_end = clip_x + $signed({2'b00, clip_size_q[10:0]});
	assign clip_y_end = clip_y + $signed({2'b00, clip_size_q[21:11]});

	assign on_screen = (px >= 13'sd0) && (py >= 13'sd0) &&
	                   (px < 13'(SCREEN_WIDTH)) && (py < 13'(SCREEN_HEIGHT));
	assign in_clip   = (px >= clip_x) && (py >= clip_y) &&
	                   (px < clip_x_end) && (py < clip_y_end);
	assign pos_ok    = on_screen && (!clip_enable_q || in_clip);

	// framebuffer index, cut to the address port
	logic [20:0] addr_full;
	assign addr_full = 21'(pos_y_s1[9:0]) * 21'(SCREEN_WIDTH) + 21'(pos_x_s1[9:0]);

	// ------------------------------------------------------------------
	// fill color, with optional blend over the destination
	// ------------------------------------------------------------------
	logic [15:0] fill_src, fill_mixed, fill_color;
	logic [7:0]  sr, sg, sb, dr, dg, db;

	assign fill_src = pack565(draw_color_q[23:16], draw_color_q[15:8], draw_color_q[7:0]);
	assign sr = EXP5[fill_src[15:11]];
	assign sg = EXP6[fill_src[10:5]];
	assign sb = EXP5[fill_src[4:0]];
	assign dr = EXP5[dest_pixel_s1[15:11]];
	assign dg = EXP6[dest_pixel_s1[10:5]];
	assign db = EXP5[dest_pixel_s1[4:0]];
	assign fill_mixed = pack565(mix(sr, dr, draw_alpha_q), mix(sg, dg, draw_alpha_q),
	                            mix(sb, db, draw_alpha_q));

	// alpha ends pass one side through untouched
	always_comb begin
		priority if (!blend_enable_q)        fill_color = fill_src;
		else if (draw_alpha_q == 8'hFF)       fill_color = fill_src;
		else if (draw_alpha_q == 8'h00)       fill_color = dest_pixel_s1;
		else                                  fill_color = fill_mixed;
	end

	// ------------------------------------------------------------------
	// texel copy: color key and per-channel modulation
	// ------------------------------------------------------------------
	logic        key_hit;
	logic [7:0]  mod_r, mod_g, mod_b;
	logic [15:0] copy_color;

	assign key_hit = color_key_q[16] && (texel_s1 == color_key_q[15:0]);
	assign mod_r   = div255(16'(texel_s1[15:11]) * 16'(tex_modulate_q[23:16]));
	assign mod_g   = div255(16'(texel_s1[10:5]) * 16'(tex_modulate_q[15:8]));
	assign mod_b   = div255(16'(texel_s1[4:0]) * 16'(tex_modulate_q[7:0]));
	assign copy_color = {mod_r[4:0], mod_g[5:0], mod_b[4:0]};

	// ------------------------------------------------------------------
	// stage 2: result register
	// ------------------------------------------------------------------
	logic              we_next;
	logic [ADDR_W-1:0] addr_next;
	logic [15:0]       color_next;

	always_comb begin
		we_next    = 1'b0;
		addr_next  = '0;
		color_next = '0;
		if (pos_ok) begin
			unique case (op_t'(operation_s1))
				OP_FILL: begin
					we_next    = 1'b1;
					color_next = fill_color;
				end
				OP_COPY: begin
					we_next    = !key_hit;
					color_next = key_hit ? 16'h0000 : copy_color;
				end
				default: ;
			endcase
			if (we_next) addr_next = addr_full[ADDR_W-1:0];
		end
	end

	logic              done_s2;
	logic              write_enable_s2;
	logic [ADDR_W-1:0] pixel_address_s2;
	logic [15:0]       pixel_color_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s2         <= 1'b0;
			write_enable_s2 <= 1'b0;
		end else begin
			done_s2         <= valid_s1;
			write_enable_s2 <= valid_s1 && we_next;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			pixel_address_s2 <= addr_next;
			pixel_color_s2   <= color_next;
		end
	end

	assign done          = done_s2;
	assign write_enable  = write_enable_s2;
	assign pixel_address = pixel_address_s2;
	assign pixel_color   = pixel_color_s2;

`ifndef SYNTHESIS
	// every accepted transfer yields its result after the input and result registers
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##2 done)
		else $error("result strobe missing after accepted transfer");

	// no result strobe without an item accepted ahead of it through both registers
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 2))
		else $error("result strobe without an accepted transfer");

	// a write enable only comes with a result
	a_we_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		write_enable |-> done)
		else $error("write enable outside a result cycle");

	// a dropped pixel carries zero address and color
	a_drop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !write_enable |-> pixel_address == '0 && pixel_color == '0)
		else $error("dropped pixel with nonzero payload");
`endif

endmodule
